// File: src/mmseg_pkg.sv
// Shared constants and helper functions of the min/max segment tree block.
package mmseg_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int LEAF_BITS    = $clog2(MAX_ELEMENTS);
  localparam int NODE_BITS    = LEAF_BITS + 1;
  localparam int COUNT_BITS   = LEAF_BITS + 1;
  localparam int WALK_BITS    = NODE_BITS + 1;
  localparam int DATA_BITS    = 32;
  localparam int RAM_DEPTH    = 2 * (2 * MAX_ELEMENTS);
  localparam int RAM_ABITS    = NODE_BITS + 1;

  localparam logic signed [DATA_BITS-1:0] INT_MIN = {1'b1, {(DATA_BITS-1){1'b0}}};
  localparam logic signed [DATA_BITS-1:0] INT_MAX = {1'b0, {(DATA_BITS-1){1'b1}}};

  typedef logic signed [DATA_BITS-1:0] data_t;

  typedef enum logic {CMD_UPDATE = 1'b0, CMD_QUERY = 1'b1} command_t;

  function automatic data_t pick(input data_t a, input data_t b, input logic use_max);
    if (use_max) begin
      return (a > b) ? a : b;
    end
    return (a < b) ? a : b;
  endfunction

  function automatic data_t identity(input logic use_max);
    return use_max ? INT_MIN : INT_MAX;
  endfunction

endpackage

// File: src/range_min_max_segment_tree.sv
// Range min/max segment tree: two trees of 2048 signed 32-bit nodes share one 4096-entry RAM,
// the tree select bit being the top address bit. After reset a clearing pass writes zero to
// all 4096 entries, one per cycle, during which no beat is accepted; the element count
// register may be written whenever no item is in progress, the clearing pass included. Items
// are handled one at a time and every cost comes from the single RAM port pair, whose read
// is registered: a range query walks at most 11 tree levels, folding in an odd left or right
// end node and halving both bounds at each; an update whose index lies among the active
// elements first writes the leaf and, for each of its 10 ancestors, reads the sibling and
// writes the parent, then every update makes the same walk as a query over all active
// elements. A finished result waits in the output register while the next beat is
// accepted; the result after it waits until that register is free.
module range_min_max_segment_tree (
  input  logic        clk,
  input  logic        rst,
  // Input beat.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // left_index[9:0], right_index[19:10], value[51:20], zero
  input  logic [1:0]  s_axis_tuser,  // command[0], select_max[1]
  // Result beat.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // result_value[31:0]
  // Element count register.
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata
);

  localparam int NB = mmseg_pkg::NODE_BITS;
  localparam int WB = mmseg_pkg::WALK_BITS;
  localparam int CB = mmseg_pkg::COUNT_BITS;
  localparam int LB = mmseg_pkg::LEAF_BITS;
  localparam int AB = mmseg_pkg::RAM_ABITS;

  localparam logic [3:0] ST_CLR    = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_LEAF   = 4'd2;
  localparam logic [3:0] ST_UP_RD  = 4'd3;
  localparam logic [3:0] ST_UP_WR  = 4'd4;
  localparam logic [3:0] ST_Q_INIT = 4'd5;
  localparam logic [3:0] ST_QA     = 4'd6;
  localparam logic [3:0] ST_QB     = 4'd7;
  localparam logic [3:0] ST_QC     = 4'd8;
  localparam logic [3:0] ST_DONE   = 4'd9;

  logic [3:0]            state;
  logic [AB-1:0]         clr_addr;
  logic [CB-1:0]         element_count;
  logic                  sel;
  logic [LB-1:0]         lo;
  logic [CB-1:0]         hi;
  logic [NB-1:0]         node;
  mmseg_pkg::data_t      cur;
  mmseg_pkg::data_t      acc;
  logic [WB-1:0]         l;
  logic [WB-1:0]         r;

  logic                  ram_we;
  logic [AB-1:0]         ram_waddr;
  logic [AB-1:0]         ram_raddr;
  mmseg_pkg::data_t      ram_wdata;
  mmseg_pkg::data_t      ram_rdata;

  logic [CB-1:0]         n_active;
  logic [CB-1:0]         hi_clip;
  logic                  q_empty;
  logic [NB-1:0]         parent;
  logic                  in_accept;

  logic                  in_cmd;
  logic                  in_sel;
  logic [LB-1:0]         in_left;
  logic [LB-1:0]         in_right;
  mmseg_pkg::data_t      in_value;

  assign in_cmd   = s_axis_tuser[0];
  assign in_sel   = s_axis_tuser[1];
  assign in_left  = s_axis_tdata[9:0];
  assign in_right = s_axis_tdata[19:10];
  assign in_value = s_axis_tdata[51:20];

  assign s_axis_tready = (state == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  assign n_active = (element_count > CB'(mmseg_pkg::MAX_ELEMENTS)) ?
                    CB'(mmseg_pkg::MAX_ELEMENTS) : element_count;
  // A zero count makes every range empty through the left-end check.
  assign q_empty  = (CB'(lo) > hi) || (CB'(lo) >= n_active);
  assign hi_clip  = (hi >= n_active) ? (n_active - CB'(1)) : hi;
  assign parent   = node >> 1;

  mmseg_ram #(
    .WIDTH(mmseg_pkg::DATA_BITS),
    .DEPTH(mmseg_pkg::RAM_DEPTH)
  ) u_tree_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {sel, node};
    ram_wdata = cur;
    ram_raddr = {sel, l[NB-1:0]};
    case (state)
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      ST_LEAF: begin
        ram_we = 1'b1;
      end
      ST_UP_RD: begin
        ram_raddr = {sel, node ^ NB'(1)};
      end
      ST_UP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = {sel, parent};
        ram_wdata = mmseg_pkg::pick(cur, ram_rdata, sel);
      end
      ST_QB: begin
        ram_raddr = {sel, r[NB-1:0] - NB'(1)};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= CB'(mmseg_pkg::MAX_ELEMENTS);
    end else if (cfg_we) begin
      element_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLR;
      clr_addr      <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // The result state reloads the output register itself.
      if (m_axis_tvalid && m_axis_tready && (state != ST_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_CLR: begin
          clr_addr <= clr_addr + AB'(1);
          if (clr_addr == {AB{1'b1}}) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_accept) begin
            sel  <= in_sel;
            cur  <= in_value;
            node <= NB'(in_left) + NB'(mmseg_pkg::MAX_ELEMENTS);
            if (in_cmd == mmseg_pkg::CMD_UPDATE) begin
              // The result of an update covers all active elements.
              lo <= '0;
              hi <= n_active - CB'(1);
              state <= (CB'(in_left) < n_active) ? ST_LEAF : ST_Q_INIT;
            end else begin
              lo    <= in_left;
              hi    <= CB'(in_right);
              state <= ST_Q_INIT;
            end
          end
        end
        ST_LEAF: begin
          state <= ST_UP_RD;
        end
        ST_UP_RD: begin
          state <= ST_UP_WR;
        end
        ST_UP_WR: begin
          cur   <= mmseg_pkg::pick(cur, ram_rdata, sel);
          node  <= parent;
          state <= (parent == NB'(1)) ? ST_Q_INIT : ST_UP_RD;
        end
        ST_Q_INIT: begin
          acc   <= mmseg_pkg::identity(sel);
          l     <= WB'(lo) + WB'(mmseg_pkg::MAX_ELEMENTS);
          r     <= WB'(hi_clip) + WB'(mmseg_pkg::MAX_ELEMENTS) + WB'(1);
          state <= q_empty ? ST_DONE : ST_QA;
        end
        ST_QA: begin
          state <= (l < r) ? ST_QB : ST_DONE;
        end
        ST_QB: begin
          if (l[0]) begin
            acc <= mmseg_pkg::pick(acc, ram_rdata, sel);
            l   <= l + WB'(1);
          end
          state <= ST_QC;
        end
        ST_QC: begin
          if (r[0]) begin
            acc <= mmseg_pkg::pick(acc, ram_rdata, sel);
          end
          // For an odd right end, (r - 1) >> 1 equals r >> 1.
          l     <= l >> 1;
          r     <= r >> 1;
          state <= ST_QA;
        end
        ST_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= acc;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // The walk of a query never lets the left bound pass the right bound.
  a_walk_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_QA) |-> (l <= r))
    else $error("query walk bounds crossed");

  // The ascent never writes above the root.
  a_ascent_root: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UP_WR) |-> (parent != '0))
    else $error("update ascent went past the root");

  // Accepting a beat always takes the input out of the ready state, so no beat follows it straight away.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> !s_axis_tready)
    else $error("input taken while an item is in progress");
`endif

endmodule

// File: src/mmseg_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module mmseg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
